// ----- src/temp_sensor_sample_qualifier_core_defines.svh -----
// Assertion macros used by the qualifier controller.
`ifndef TEMP_SENSOR_SAMPLE_QUALIFIER_CORE_DEFINES_SVH
`define TEMP_SENSOR_SAMPLE_QUALIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TSSQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TSSQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tssq_pkg.sv -----
package tssq_pkg;

    // Default counter width in bits
    localparam int TIME_BITS_DEF = 16;

    // Register field widths
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TEMP_W = 12;
    localparam int FAIL_W = 8;
    localparam int MS_W = 16;

    // Temperature codes in 1/16 C
    localparam logic signed [TEMP_W-1:0] POWER_ON_VALUE = 12'sd1360;
    localparam logic signed [TEMP_W-1:0] DISCONNECTED_VALUE = -12'sd2032;
    localparam logic [FAIL_W-1:0] FAIL_MAX = 8'd255;

    // Register reset values
    localparam logic [MS_W-1:0] CONV_TIME_RST = 16'd750;
    localparam logic [MS_W-1:0] SAMPLE_INT_RST = 16'd1000;
    localparam logic [MS_W-1:0] MAX_AGE_RST = 16'd5000;
    localparam logic [FAIL_W-1:0] REINIT_RST = 8'd3;
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST = -12'sd320;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 12'sd2000;

    // Modulo unit: two quotient bits per step
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS = FAIL_W / DIV_BITS_PER_STEP;
    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONV_TIME  = 3'd0,
        CFG_SAMPLE_INT = 3'd1,
        CFG_MAX_AGE    = 3'd2,
        CFG_REINIT     = 3'd3,
        CFG_LOW_LIMIT  = 3'd4,
        CFG_HIGH_LIMIT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        ACT_TICK    = 1'b0,
        ACT_READING = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rejected;
    } t_dp_status;

endpackage

// ----- src/temp_sensor_sample_qualifier_core.sv -----
// Two-sensor temperature sample qualifier.
// Input channel (i_in_valid / o_in_ready): each item is a 1 ms tick
// (i_action = 0) or a reading (i_action = 1) for sensor i_sensor.
// Output channel (o_out_valid / i_out_ready): one result per item with the
// conversion flags, the bus reinit flag and the status of both sensors.
// Config channel (i_cfg_valid / o_cfg_ready): register index and data;
// always ready. The user must write it only while no item is in flight;
// the block itself does not enforce this. A tick or an accepted reading
// goes from the execute state to the finish state, which loads the result;
// a rejected reading first runs the modulo state, where the 2-bit-per-step
// remainder unit tests the failure count against the reinit multiple.
// The controller handles one item at a time.
// The result sits in an output register, so the next item is accepted
// while it waits; a stalled receiver holds the block in its final state
// until the register frees up.
// Reset (synchronous, active low) loads register defaults, marks a
// conversion pending, clears stored readings and failures and saturates
// the reading ages; no clearing pass is needed.
module temp_sensor_sample_qualifier_core #(
    parameter int TIME_BITS = tssq_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tssq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tssq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic                                 i_sensor,
    input  logic signed [tssq_pkg::TEMP_W-1:0]   i_temperature,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_start_conversion,
    output logic                                 o_read_due,
    output logic                                 o_reinit_bus,
    output logic                                 o_pot_usable,
    output logic                                 o_pot_healthy,
    output logic signed [tssq_pkg::TEMP_W-1:0]   o_pot_temperature,
    output logic [tssq_pkg::FAIL_W-1:0]          o_pot_failures,
    output logic                                 o_valve_usable,
    output logic                                 o_valve_healthy,
    output logic signed [tssq_pkg::TEMP_W-1:0]   o_valve_temperature,
    output logic [tssq_pkg::FAIL_W-1:0]          o_valve_failures
);
    import tssq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    tssq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tssq_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_action            (i_action),
        .i_sensor            (i_sensor),
        .i_temperature       (i_temperature),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_start_conversion  (o_start_conversion),
        .o_read_due          (o_read_due),
        .o_reinit_bus        (o_reinit_bus),
        .o_pot_usable        (o_pot_usable),
        .o_pot_healthy       (o_pot_healthy),
        .o_pot_temperature   (o_pot_temperature),
        .o_pot_failures      (o_pot_failures),
        .o_valve_usable      (o_valve_usable),
        .o_valve_healthy     (o_valve_healthy),
        .o_valve_temperature (o_valve_temperature),
        .o_valve_failures    (o_valve_failures)
    );

endmodule

// ----- src/tssq_ctrl.sv -----
`include "temp_sensor_sample_qualifier_core_defines.svh"

module tssq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tssq_pkg::t_dp_cmd    o_cmd,
    input  tssq_pkg::t_dp_status i_status
);
    import tssq_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_status.rejected ? ST_MOD : ST_FINISH;
            end
            ST_MOD: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        n_step = r_step;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_step = '0;
            end
            ST_MOD: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
            end
            ST_FINISH: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `TSSQ_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_EXEC, "accepted item did not start execution")
    `TSSQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready, "pending result overwritten")
    `TSSQ_ASSERT_NXT(a_good_skip_mod, i_clk, i_rst_n, r_state == ST_EXEC && !i_status.rejected, r_state == ST_FINISH, "modulo run on an accepted item")

endmodule

// ----- src/tssq_datapath.sv -----
module tssq_datapath #(
    parameter int TIME_BITS = tssq_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [tssq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tssq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_action,
    input  logic                                 i_sensor,
    input  logic signed [tssq_pkg::TEMP_W-1:0]   i_temperature,
    input  tssq_pkg::t_dp_cmd                    i_cmd,
    output tssq_pkg::t_dp_status                 o_status,
    output logic                                 o_start_conversion,
    output logic                                 o_read_due,
    output logic                                 o_reinit_bus,
    output logic                                 o_pot_usable,
    output logic                                 o_pot_healthy,
    output logic signed [tssq_pkg::TEMP_W-1:0]   o_pot_temperature,
    output logic [tssq_pkg::FAIL_W-1:0]          o_pot_failures,
    output logic                                 o_valve_usable,
    output logic                                 o_valve_healthy,
    output logic signed [tssq_pkg::TEMP_W-1:0]   o_valve_temperature,
    output logic [tssq_pkg::FAIL_W-1:0]          o_valve_failures
);
    import tssq_pkg::*;

    // Compare width covers both the counters and the 16-bit thresholds
    localparam int CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    // Configuration registers
    logic [MS_W-1:0]          r_conv_time, r_sample_int, r_max_age;
    logic [FAIL_W-1:0]        r_reinit_after;
    logic signed [TEMP_W-1:0] r_low_limit, r_high_limit;

    // Block state
    logic                     r_pending;
    logic [TIME_BITS-1:0]     r_elapsed;
    logic signed [TEMP_W-1:0] r_last_good [2];
    logic [TIME_BITS-1:0]     r_age [2];
    logic                     r_has_good [2];
    logic [FAIL_W-1:0]        r_fail [2];

    // Captured item and per-item flags
    logic                     r_action, r_sensor;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_rejected, r_start, r_due;

    // Modulo unit
    logic [FAIL_W:0]          r_rem, n_rem;
    logic [FAIL_W-1:0]        r_dvd, n_dvd;

    // Tick arithmetic
    logic [TIME_BITS-1:0]     elapsed_inc;
    logic [TIME_BITS-1:0]     age_inc [2];
    logic                     tick_due, tick_pend, tick_start;

    // Reading qualification
    logic                     qual;
    logic [FAIL_W-1:0]        fail_next;

    // Status for output
    logic                     usable [2];

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_BITS'(1);

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            age_inc[s] = (r_age[s] == '1) ? r_age[s] : r_age[s] + TIME_BITS'(1);
        end
    end

    // Conversion scheduling on a tick
    always_comb begin
        tick_due = r_pending && (CW'(elapsed_inc) >= CW'(r_conv_time));
        tick_pend = r_pending && !tick_due;
        tick_start = !tick_pend && (CW'(elapsed_inc) >= CW'(r_sample_int));
    end

    // Limit check, disconnect code, power-on code before the first good value
    always_comb begin
        qual = (r_temp != DISCONNECTED_VALUE) && (r_temp >= r_low_limit)
            && (r_temp <= r_high_limit)
            && (r_has_good[r_sensor] || (r_temp != POWER_ON_VALUE));
        fail_next = (r_fail[r_sensor] < FAIL_MAX) ? r_fail[r_sensor] + FAIL_W'(1)
                                                 : r_fail[r_sensor];
    end

    assign o_status.rejected = (r_action == ACT_READING) && !qual;

    // Restoring remainder, two dividend bits per step
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            n_rem = {n_rem[FAIL_W-1:0], n_dvd[FAIL_W-1]};
            n_dvd = {n_dvd[FAIL_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_reinit_after}) n_rem = n_rem - {1'b0, r_reinit_after};
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_time <= CONV_TIME_RST;
            r_sample_int <= SAMPLE_INT_RST;
            r_max_age <= MAX_AGE_RST;
            r_reinit_after <= REINIT_RST;
            r_low_limit <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CONV_TIME:  r_conv_time <= i_cfg_data;
                CFG_SAMPLE_INT: r_sample_int <= i_cfg_data;
                CFG_MAX_AGE:    r_max_age <= i_cfg_data;
                CFG_REINIT:     r_reinit_after <= i_cfg_data[FAIL_W-1:0];
                CFG_LOW_LIMIT:  r_low_limit <= i_cfg_data[TEMP_W-1:0];
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_sensor <= i_sensor;
            r_temp <= i_temperature;
        end
    end

    // State update for one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
            r_elapsed <= '0;
            r_rejected <= 1'b0;
            r_start <= 1'b0;
            r_due <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_last_good[s] <= '0;
                r_age[s] <= '1;
                r_has_good[s] <= 1'b0;
                r_fail[s] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_rejected <= o_status.rejected;
            if (r_action == ACT_TICK) begin
                r_due <= tick_due;
                r_start <= tick_start;
                r_pending <= tick_pend || tick_start;
                r_elapsed <= tick_start ? '0 : elapsed_inc;
                for (int s = 0; s < 2; s++) r_age[s] <= age_inc[s];
            end else begin
                r_due <= 1'b0;
                r_start <= 1'b0;
                if (qual) begin
                    r_last_good[r_sensor] <= r_temp;
                    r_age[r_sensor] <= '0;
                    r_fail[r_sensor] <= '0;
                    r_has_good[r_sensor] <= 1'b1;
                end else begin
                    r_fail[r_sensor] <= fail_next;
                end
            end
        end
    end

    // Modulo unit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rem <= '0;
            r_dvd <= fail_next;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    // Sensor status
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            usable[s] = r_has_good[s] && (CW'(r_age[s]) <= CW'(r_max_age));
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_start_conversion <= r_start;
            o_read_due <= r_due;
            o_reinit_bus <= r_rejected && (r_reinit_after != '0) && (r_rem == '0);
            o_pot_usable <= usable[0];
            o_pot_healthy <= usable[0] && (r_fail[0] == '0);
            o_pot_temperature <= usable[0] ? r_last_good[0] : '0;
            o_pot_failures <= r_fail[0];
            o_valve_usable <= usable[1];
            o_valve_healthy <= usable[1] && (r_fail[1] == '0);
            o_valve_temperature <= usable[1] ? r_last_good[1] : '0;
            o_valve_failures <= r_fail[1];
        end
    end

endmodule
